// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL. Both sample on clk and are disabled
// while rst is high, so a module that uses them must have those two names.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/cmap_pkg.sv =====
// ----------------------------------------------------------------------------
// Colormap package
// Shared types, channel constants and codes for the scalar-to-RGBA colormap.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cmap_pkg;

  localparam int VALUE_W         = 32;
  localparam int VALUE_FRAC_BITS = 16;
  localparam int VALUE_INT_W     = VALUE_W - 1 - VALUE_FRAC_BITS;
  localparam int CH_FRAC_BITS    = 12;
  localparam int CH_W            = CH_FRAC_BITS + 1;
  localparam int SPAN_W          = VALUE_W + 1;
  localparam int SCALED_W        = SPAN_W + 3;
  localparam int TAG_IDX_W       = 6;
  localparam int CFG_IDX_W       = 3;
  localparam int QUEUE_DEPTH     = 4;
  localparam int QUEUE_PTR_W     = 2;
  localparam int QUEUE_CNT_W     = 3;

  localparam logic [CH_W-1:0] CH_ONE  = 13'd4096;
  localparam logic [CH_W-1:0] CH_HALF = 13'd2048;
  localparam logic [CH_W-1:0] CH_P33  = 13'd1352;
  localparam logic [CH_W-1:0] CH_P66  = 13'd2703;

  // Reciprocal multipliers: floor(2^S / N), then one correction step.
  localparam int              DIV3_SHIFT   = 14;
  localparam logic [13:0]     DIV3_MUL     = 14'd5461;
  localparam int              DIV100_SHIFT = 26;
  localparam logic [19:0]     DIV100_MUL   = 20'd671088;

  localparam logic [1:0] MODE_FIVE = 2'd0;
  localparam logic [1:0] MODE_FOUR = 2'd1;
  localparam logic [1:0] MODE_TAG  = 2'd2;
  localparam logic [1:0] MODE_GREY = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_MODE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MIN      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MAX      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SHOW_BELOW_MIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SHOW_ABOVE_MAX = 3'd4;

  localparam logic FUNC_CONVERT = 1'b0;
  localparam logic FUNC_WRITE   = 1'b1;

  typedef enum logic [2:0] {
    SEG_BELOW = 3'd0,
    SEG_0     = 3'd1,
    SEG_1     = 3'd2,
    SEG_2     = 3'd3,
    SEG_3     = 3'd4,
    SEG_ABOVE = 3'd5
  } seg_t;

  typedef struct packed {
    logic                    func;
    logic signed [VALUE_W-1:0] value;
    logic [CH_W-1:0]         alpha_in;
    logic [4:0]              tag_index;
    logic [CH_W-1:0]         tag_red;
    logic [CH_W-1:0]         tag_green;
    logic [CH_W-1:0]         tag_blue;
    logic [CH_W-1:0]         tag_opacity;
  } cmap_in_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] opacity;
  } cmap_out_t;

  // One classified item as it travels from the front end to the back end.
  typedef struct packed {
    logic                 func;
    seg_t                 seg;
    logic [CH_W-1:0]      alpha;
    logic [TAG_IDX_W-1:0] idx;
    logic                 wr_ok;
    cmap_out_t            tag_color;
    logic [VALUE_W-1:0]   num;
  } cmap_op_t;

  typedef struct packed {
    logic [QUEUE_CNT_W-1:0] count;
    logic                   push;
    logic                   pop;
    logic                   full;
    logic                   empty;
  } cmap_qstat_t;

endpackage

`default_nettype wire

// ===== rtl/cmap_front.sv =====
// ----------------------------------------------------------------------------
// Colormap front end
// Accepts items, finds the ramp segment and its numerator, and reduces the
// integer part of the value to a tag table index.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cmap_front #(
  parameter int TAG_ENTRIES = 25
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire cmap_pkg::cmap_in_t                in_data,
  input  wire logic [1:0]                        scale_mode,
  input  wire logic signed [cmap_pkg::VALUE_W-1:0] range_min,
  input  wire logic signed [cmap_pkg::SPAN_W-1:0]  span,
  input  wire logic                              full,
  output logic                                   push,
  output cmap_pkg::cmap_op_t                     push_data
);
  import cmap_pkg::*;

  localparam int IW   = $clog2(TAG_ENTRIES);
  localparam int TW   = ((IW + 1) > 5) ? (IW + 1) : 5;
  localparam int RS   = VALUE_INT_W + IW + 1;
  localparam int PW   = VALUE_INT_W + RS;
  localparam int QW   = VALUE_INT_W + 7;
  localparam logic [RS-1:0] RMUL = RS'((1 << RS) / TAG_ENTRIES);

  logic en;

  logic v1, v2, v3, v4, v5;
  cmap_in_t d1, d2, d3, d4, d5;

  logic signed [SPAN_W-1:0]   t2;
  logic [VALUE_INT_W-1:0]     ip2, ip3;
  logic [PW-1:0]              rp2;
  logic                       wr_ok2, wr_ok3, wr_ok4, wr_ok5;
  logic [IW-1:0]              widx2, widx3, widx4, widx5;

  logic signed [SCALED_W-1:0] pt3;
  logic                       neg3;
  logic [VALUE_INT_W-1:0]     qe3;

  seg_t                       seg4, seg5;
  logic [VALUE_W-1:0]         num4, num5;
  logic [IW:0]                r4;
  logic [IW-1:0]              ridx5;

  logic signed [SCALED_W-1:0] dk1, dk2, dk3, dk4;

  logic signed [SCALED_W-1:0] t_ext;
  logic [TW-1:0]              tag_ext;
  logic [QW-1:0]              qn3;
  logic [QW-1:0]              rdiff3;
  seg_t                       seg_c;
  logic signed [SCALED_W-1:0] sub_c;
  logic [IW:0]                rfix4;

  assign en       = !v5 || !full;
  assign in_ready = en;
  assign push     = v5 && !full;

  // Segment thresholds follow the range registers.
  always_ff @(posedge clk) begin
    dk1 <= SCALED_W'(span);
    dk2 <= SCALED_W'(span) <<< 1;
    dk3 <= SCALED_W'(span) + (SCALED_W'(span) <<< 1);
    dk4 <= SCALED_W'(span) <<< 2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  always_comb begin
    t_ext   = SCALED_W'(t2);
    tag_ext = TW'(d1.tag_index);
    qn3     = QW'(qe3) * QW'(TAG_ENTRIES);
    rdiff3  = QW'(ip3) - qn3;
    seg_c   = SEG_ABOVE;
    sub_c   = '0;
    if (neg3) begin
      seg_c = SEG_BELOW;
    end else if (pt3 < dk1) begin
      seg_c = SEG_0;
    end else if (pt3 < dk2) begin
      seg_c = SEG_1;
      sub_c = dk1;
    end else if (pt3 < dk3) begin
      seg_c = SEG_2;
      sub_c = dk2;
    end else if ((scale_mode == MODE_FIVE) && (pt3 < dk4)) begin
      seg_c = SEG_3;
      sub_c = dk3;
    end
    rfix4 = (r4 >= (IW+1)'(TAG_ENTRIES)) ? r4 - (IW+1)'(TAG_ENTRIES) : r4;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1 <= in_data;

      d2     <= d1;
      t2     <= {d1.value[VALUE_W-1], d1.value} - {range_min[VALUE_W-1], range_min};
      ip2    <= d1.value[VALUE_W-1] ? '0 : d1.value[VALUE_W-2:VALUE_FRAC_BITS];
      rp2    <= PW'(d1.value[VALUE_W-1] ? '0 : d1.value[VALUE_W-2:VALUE_FRAC_BITS])
                * PW'(RMUL);
      wr_ok2 <= tag_ext < TW'(TAG_ENTRIES);
      widx2  <= tag_ext[IW-1:0];

      d3     <= d2;
      neg3   <= t2[SPAN_W-1];
      pt3    <= (scale_mode == MODE_FIVE) ? (t_ext <<< 2) : (t_ext + (t_ext <<< 1));
      qe3    <= VALUE_INT_W'(rp2 >> RS);
      ip3    <= ip2;
      wr_ok3 <= wr_ok2;
      widx3  <= widx2;

      d4     <= d3;
      seg4   <= seg_c;
      num4   <= VALUE_W'(pt3 - sub_c);
      r4     <= rdiff3[IW:0];
      wr_ok4 <= wr_ok3;
      widx4  <= widx3;

      d5     <= d4;
      seg5   <= seg4;
      num5   <= num4;
      ridx5  <= rfix4[IW-1:0];
      wr_ok5 <= wr_ok4;
      widx5  <= widx4;
    end
  end

  always_comb begin
    push_data.func      = d5.func;
    push_data.seg       = seg5;
    push_data.alpha     = d5.alpha_in;
    push_data.idx       = TAG_IDX_W'((d5.func == FUNC_WRITE) ? widx5 : ridx5);
    push_data.wr_ok     = wr_ok5;
    push_data.tag_color = '{red: d5.tag_red, green: d5.tag_green,
                            blue: d5.tag_blue, opacity: d5.tag_opacity};
    push_data.num       = num5;
  end

endmodule

`default_nettype wire

// ===== rtl/cmap_queue.sv =====
// ----------------------------------------------------------------------------
// Colormap decoupling queue
// A short FIFO of classified items between the front and back ends.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cmap_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire cmap_pkg::cmap_op_t push_data,
  input  wire logic               pop,
  output cmap_pkg::cmap_op_t      head,
  output cmap_pkg::cmap_qstat_t   stat
);
  import cmap_pkg::*;

  cmap_op_t               slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wptr, rptr;
  logic [QUEUE_CNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_data;
    end
  end

  assign head       = slots[rptr];
  assign stat.count = count;
  assign stat.push  = push;
  assign stat.pop   = pop;
  assign stat.full  = (count == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign stat.empty = (count == '0);

endmodule

`default_nettype wire

// ===== rtl/cmap_back.sv =====
// ----------------------------------------------------------------------------
// Colormap back end
// Pipelined restoring divider for the ramp fraction, the constant-ratio
// scalings, the tag color table and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cmap_back #(
  parameter int TAG_ENTRIES = 25
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire cmap_pkg::cmap_op_t          head,
  input  wire logic                        empty,
  output logic                             pop,
  input  wire logic [1:0]                  scale_mode,
  input  wire logic [cmap_pkg::VALUE_W-1:0] divisor,
  input  wire logic                        show_below_min,
  input  wire logic                        show_above_max,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output cmap_pkg::cmap_out_t              out_data
);
  import cmap_pkg::*;

  localparam int IW    = $clog2(TAG_ENTRIES);
  localparam int DIV_W = CH_FRAC_BITS;
  localparam int F_W   = CH_FRAC_BITS;

  logic en;

  // Divider pipeline: stage 0 holds the numerator, each next stage one bit.
  logic                 dv   [DIV_W+1];
  cmap_op_t             dop  [DIV_W+1];
  logic [VALUE_W-1:0]   drem [DIV_W+1];
  logic [DIV_W-1:0]     dq   [DIV_W+1];
  logic [VALUE_W:0]     trial [DIV_W];
  logic                 ge    [DIV_W];

  logic                 v1, v2, v3;
  cmap_op_t             op1, op2, op3;
  logic [F_W-1:0]       f1, f2, f3v;
  logic [F_W+13:0]      m3_1;
  logic [18:0]          p66_1, p66_2;
  logic [11:0]          q3e2;
  logic [38:0]          m100_2;
  logic [11:0]          third3;
  logic [CH_W-1:0]      b66_3;

  logic [13:0]          r3;
  logic [12:0]          q100e;
  logic [18:0]          r100;

  cmap_out_t            tab    [TAG_ENTRIES];
  logic                 tvalid [TAG_ENTRIES];
  cmap_out_t            tab_rd;
  cmap_out_t            color;
  logic [CH_W-1:0]      fe, th;
  logic [IW-1:0]        tidx;

  assign en  = !out_valid || out_ready;
  assign pop = en && !empty;

  always_comb begin
    for (int i = 0; i < DIV_W; i++) begin
      trial[i] = {drem[i], 1'b0};
      ge[i]    = trial[i] >= {1'b0, divisor};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= DIV_W; i++) begin
        dv[i] <= 1'b0;
      end
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      dv[0] <= pop;
      for (int i = 0; i < DIV_W; i++) begin
        dv[i+1] <= dv[i];
      end
      v1 <= dv[DIV_W];
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dop[0]  <= head;
      drem[0] <= head.num;
      dq[0]   <= '0;
      for (int i = 0; i < DIV_W; i++) begin
        dop[i+1]  <= dop[i];
        drem[i+1] <= ge[i] ? VALUE_W'(trial[i] - {1'b0, divisor}) : VALUE_W'(trial[i]);
        dq[i+1]   <= {dq[i][DIV_W-2:0], ge[i]};
      end
    end
  end

  // f/3 and 66*f/100 by reciprocal multiply and one correction.
  always_comb begin
    r3    = 14'(f2) - 14'(q3e2) * 14'd3;
    q100e = 13'(m100_2 >> DIV100_SHIFT);
    r100  = p66_2 - 19'(q100e) * 19'd100;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op1   <= dop[DIV_W];
      f1    <= dq[DIV_W];
      m3_1  <= (F_W+14)'(dq[DIV_W]) * (F_W+14)'(DIV3_MUL);
      p66_1 <= 19'(dq[DIV_W]) * 19'd66;

      op2    <= op1;
      f2     <= f1;
      q3e2   <= 12'(m3_1 >> DIV3_SHIFT);
      p66_2  <= p66_1;
      m100_2 <= 39'(p66_1) * 39'(DIV100_MUL);

      op3    <= op2;
      f3v    <= f2;
      third3 <= q3e2 + ((r3 >= 14'd3) ? 12'd1 : 12'd0);
      b66_3  <= q100e + ((r100 >= 19'd100) ? 13'd1 : 13'd0);
    end
  end

  assign tidx   = op3.idx[IW-1:0];
  assign tab_rd = tvalid[tidx] ? tab[tidx] : '0;
  assign fe     = CH_W'(f3v);
  assign th     = CH_W'(third3);

  always_comb begin
    color = '{red: CH_HALF, green: CH_HALF, blue: CH_HALF, opacity: CH_HALF};
    case (scale_mode)
      MODE_FIVE: begin
        case (op3.seg)
          SEG_BELOW: color = '{red: '0, green: '0, blue: CH_ONE,
                               opacity: show_below_min ? op3.alpha : '0};
          SEG_0:     color = '{red: '0, green: fe, blue: CH_ONE, opacity: op3.alpha};
          SEG_1:     color = '{red: '0, green: CH_ONE, blue: CH_ONE - fe,
                               opacity: op3.alpha};
          SEG_2:     color = '{red: fe, green: CH_ONE, blue: '0, opacity: op3.alpha};
          SEG_3:     color = '{red: CH_ONE, green: CH_ONE - fe, blue: '0,
                               opacity: op3.alpha};
          default:   color = '{red: CH_ONE, green: '0, blue: '0,
                               opacity: show_above_max ? op3.alpha : '0};
        endcase
      end
      MODE_FOUR: begin
        case (op3.seg)
          SEG_BELOW: color = '{red: CH_HALF, green: '0, blue: '0, opacity: '0};
          SEG_0:     color = '{red: CH_HALF + (fe >> 1), green: '0, blue: '0,
                               opacity: th};
          SEG_1:     color = '{red: CH_ONE, green: fe, blue: '0,
                               opacity: CH_P33 + th};
          SEG_2:     color = '{red: CH_ONE, green: CH_ONE, blue: b66_3,
                               opacity: CH_P66 + th};
          default:   color = '{red: CH_ONE, green: CH_ONE, blue: CH_P66,
                               opacity: CH_ONE};
        endcase
      end
      MODE_TAG:  color = tab_rd;
      default:   color = '{red: CH_HALF, green: CH_HALF, blue: CH_HALF, opacity: CH_HALF};
    endcase
  end

  // Table writes land in the same stage as table reads, so item order holds.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TAG_ENTRIES; i++) begin
        tvalid[i] <= 1'b0;
      end
    end else if (en && v3 && op3.func == FUNC_WRITE && op3.wr_ok) begin
      tvalid[tidx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en && v3 && op3.func == FUNC_WRITE && op3.wr_ok) begin
      tab[tidx] <= op3.tag_color;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v3 && (op3.func == FUNC_CONVERT);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= color;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/scalar_to_rgba_colormap_unit.sv =====
// ----------------------------------------------------------------------------
// Scalar to RGBA colormap unit
// Maps Q16.16 scalars to Q1.12 RGBA colors by ramp or tag table lookup.
// ----------------------------------------------------------------------------
// The unit takes one item per clock, while the output does not stall, and
// returns one color per convert beat, none per table write beat, in order. An
// input beat passes five front-end stages that classify the value, one queue
// slot, a numerator register and a twelve-stage restoring divider that forms
// the ramp fraction, three scaling stages and the output register.
// Throughput is one beat per cycle while the output does not stall, set by the
// one-bit-per-stage divider pipeline. The four-entry queue lets the front end
// keep accepting beats for a while when the output stalls.
// Configuration writes are taken at any time but must only be issued while
// the unit holds no work.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module scalar_to_rgba_colormap_unit #(
  parameter int TAG_ENTRIES = 25
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire cmap_pkg::cmap_in_t               in_data,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output cmap_pkg::cmap_out_t                   out_data,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [cmap_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [cmap_pkg::VALUE_W-1:0]     cfg_data
);
  import cmap_pkg::*;

  logic [1:0]                 scale_mode;
  logic signed [VALUE_W-1:0]  range_min;
  logic signed [VALUE_W-1:0]  range_max;
  logic                       show_below_min;
  logic                       show_above_max;
  logic signed [SPAN_W-1:0]   span;

  logic        q_push, q_pop;
  cmap_op_t    q_in, q_head;
  cmap_qstat_t q_stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_mode     <= MODE_FIVE;
      range_min      <= '0;
      range_max      <= '0;
      show_below_min <= 1'b0;
      show_above_max <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SCALE_MODE:     scale_mode     <= cfg_data[1:0];
        CFG_RANGE_MIN:      range_min      <= cfg_data;
        CFG_RANGE_MAX:      range_max      <= cfg_data;
        CFG_SHOW_BELOW_MIN: show_below_min <= cfg_data[0];
        CFG_SHOW_ABOVE_MAX: show_above_max <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    span <= {range_max[VALUE_W-1], range_max} - {range_min[VALUE_W-1], range_min};
  end

  cmap_front #(.TAG_ENTRIES(TAG_ENTRIES)) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .scale_mode (scale_mode),
    .range_min  (range_min),
    .span       (span),
    .full       (q_stat.full),
    .push       (q_push),
    .push_data  (q_in)
  );

  cmap_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .stat      (q_stat)
  );

  cmap_back #(.TAG_ENTRIES(TAG_ENTRIES)) u_back (
    .clk            (clk),
    .rst            (rst),
    .head           (q_head),
    .empty          (q_stat.empty),
    .pop            (q_pop),
    .scale_mode     (scale_mode),
    .divisor        (span[VALUE_W-1:0]),
    .show_below_min (show_below_min),
    .show_above_max (show_above_max),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data)
  );

  `ASSERT_SAME(a_queue_bound, 1'b1, q_stat.count <= QUEUE_CNT_W'(QUEUE_DEPTH))
  `ASSERT_SAME(a_no_push_full, q_stat.full, !q_stat.push || q_stat.pop)
  `ASSERT_NEXT(a_full_holds, q_stat.full && !q_stat.pop, q_stat.full)
  `ASSERT_SAME(a_ramp_range, out_valid && (scale_mode != MODE_TAG),
               out_data.red <= CH_ONE && out_data.green <= CH_ONE && out_data.blue <= CH_ONE)

endmodule

`default_nettype wire
